FILE: rtl/fbc_pkg.sv
// shared types, constants and helpers for the frustum box cull block
`default_nettype none

package fbc_pkg;

  // plane set and cube geometry
  localparam int NumPlanes = 6;
  localparam int CubeSide  = 32;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  // fixed point plane coefficients
  localparam int CoefW  = 14;
  localparam int OffW   = 22;
  localparam int ChunkW = 16;

  // corner coordinates hold chunk * side - 1 .. chunk * side + side
  localparam int CoordW = ChunkW + $clog2(CubeSide) + 1;
  localparam int ProdW  = CoefW + CoordW;
  localparam int SumW   = ProdW + 2;

  // one plane as it sits in its register
  typedef struct packed {
    logic signed [OffW-1:0]  d;
    logic signed [CoefW-1:0] c;
    logic signed [CoefW-1:0] b;
    logic signed [CoefW-1:0] a;
  } plane_t;

  typedef plane_t [NumPlanes-1:0] plane_set_t;

  // lower corner of the cube on one axis
  function automatic logic signed [CoordW-1:0] corner_base(logic signed [ChunkW-1:0] chunk);
    logic signed [CoordW-1:0] ext;
    ext = CoordW'(chunk);
    return ext * CoordW'(CubeSide) - CoordW'(1);
  endfunction

  // span from the lower to the upper corner along one axis, CubeSide + 1
  localparam logic signed [CoordW-1:0] CubeSpan = CoordW'(CubeSide + 1);

endpackage

`default_nettype wire

FILE: rtl/fbc_plane_regs.sv
// configuration registers holding the six frustum planes
`default_nettype none

module fbc_plane_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [fbc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [fbc_pkg::CfgDataW-1:0]  cfg_data_i,
  output fbc_pkg::plane_set_t                planes_o
);
  import fbc_pkg::*;

  plane_set_t planes_q, planes_d;

  // a beat with an index past the last plane changes nothing
  always_comb begin
    planes_d = planes_q;
    for (int p = 0; p < NumPlanes; p++) begin
      if (cfg_valid_i && (cfg_index_i == CfgIdxW'(p))) begin
        planes_d[p] = plane_t'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      planes_q <= '0;
    end else begin
      planes_q <= planes_d;
    end
  end

  assign planes_o = planes_q;

endmodule

`default_nettype wire

FILE: rtl/fbc_plane_lane.sv
// one plane test: largest corner distance and its sign
`default_nettype none

module fbc_plane_lane (
  input  wire logic                          clk_i,
  input  wire logic signed [fbc_pkg::CoordW-1:0] base_x_i,
  input  wire logic signed [fbc_pkg::CoordW-1:0] base_y_i,
  input  wire logic signed [fbc_pkg::CoordW-1:0] base_z_i,
  input  wire fbc_pkg::plane_t               plane_i,
  output logic                               inside_o
);
  import fbc_pkg::*;

  logic signed [CoefW-1:0]  coef_a, coef_b, coef_c;
  logic signed [CoordW-1:0] sel_x, sel_y, sel_z;
  logic signed [ProdW-1:0]  prod_a_q, prod_b_q, prod_c_q;
  logic signed [OffW-1:0]   off_q;
  logic signed [SumW-1:0]   best_dist;

  assign coef_a = plane_i.a;
  assign coef_b = plane_i.b;
  assign coef_c = plane_i.c;

  // the corner farthest along the plane normal gives the largest distance
  assign sel_x = coef_a[CoefW-1] ? base_x_i : base_x_i + CubeSpan;
  assign sel_y = coef_b[CoefW-1] ? base_y_i : base_y_i + CubeSpan;
  assign sel_z = coef_c[CoefW-1] ? base_z_i : base_z_i + CubeSpan;

  // product stage
  always_ff @(posedge clk_i) begin
    prod_a_q <= ProdW'(coef_a) * ProdW'(sel_x);
    prod_b_q <= ProdW'(coef_b) * ProdW'(sel_y);
    prod_c_q <= ProdW'(coef_c) * ProdW'(sel_z);
    off_q    <= plane_i.d;
  end

  // sum and sign test of the best corner
  assign best_dist = SumW'(prod_a_q) + SumW'(prod_b_q) + SumW'(prod_c_q) + SumW'(off_q);
  assign inside_o = !best_dist[SumW-1];

endmodule

`default_nettype wire

FILE: rtl/frustum_box_cull.sv
// top level of the frustum box cull block
//
// Tests one chunk cube against six frustum planes and reports visibility.
// Input channel: chunk_x_i, chunk_z_i, chunk_y_i are taken at a rising edge
// with start high and busy low. busy stays low, so a chunk can be started
// in every cycle and throughput is one chunk per clock.
// Result channel: done_o is high for one cycle with visible_o; the result
// for a chunk passes the input register, the product register and the
// result register after its start beat. Results come out in start order.
// The receiver has no way to hold results off and none is needed.
// Configuration: a beat on cfg_valid_i/cfg_ready_o writes plane register
// cfg_index_i; indexes past five are dropped. cfg_ready_o is always high.
// The user must write planes only while no chunk is in flight; the block
// does not enforce it. Reset: all planes clear to zero, which makes every
// chunk visible, and the pipeline drops any chunk in flight.
`default_nettype none

module frustum_box_cull (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [fbc_pkg::ChunkW-1:0] chunk_x_i,
  input  wire logic signed [fbc_pkg::ChunkW-1:0] chunk_z_i,
  input  wire logic signed [fbc_pkg::ChunkW-1:0] chunk_y_i,
  output logic                               done_o,
  output logic                               visible_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [fbc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [fbc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import fbc_pkg::*;

  logic                     accept;
  logic                     in_vld_q, prod_vld_q, out_vld_q;
  logic signed [CoordW-1:0] base_x_q, base_y_q, base_z_q;
  logic [NumPlanes-1:0]     plane_pass;
  logic                     visible_q;
  plane_set_t               planes;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // plane storage
  fbc_plane_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .planes_o    (planes)
  );

  // input register: lower cube corner on each axis
  always_ff @(posedge clk_i) begin
    if (accept) begin
      base_x_q <= corner_base(chunk_x_i);
      base_y_q <= corner_base(chunk_y_i);
      base_z_q <= corner_base(chunk_z_i);
    end
  end

  // one lane per plane
  for (genvar p = 0; p < NumPlanes; p++) begin : g_lane
    fbc_plane_lane u_lane (
      .clk_i    (clk_i),
      .base_x_i (base_x_q),
      .base_y_i (base_y_q),
      .base_z_i (base_z_q),
      .plane_i  (planes[p]),
      .inside_o (plane_pass[p])
    );
  end

  // result register: culled if any plane has the whole cube behind it
  always_ff @(posedge clk_i) begin
    visible_q <= &plane_pass;
  end

  // beat tracking down the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      in_vld_q   <= accept;
      prod_vld_q <= in_vld_q;
      out_vld_q  <= prod_vld_q;
    end
  end

  assign done_o    = out_vld_q;
  assign visible_o = visible_q;

  // every start beat gives a result at the end of the pipeline
  a_start_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("start beat without result");

  // no result without a start beat that entered the pipeline
  a_done_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 3))
    else $error("result without start beat");

  // writes past the last plane leave the planes untouched
  a_cfg_ignore : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && (cfg_index_i >= CfgIdxW'(NumPlanes)))
      |=> $stable(planes))
    else $error("plane changed by out of range write");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// self-checking testbench for the frustum box cull block
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fbc_pkg::*;

  // run shape
  localparam int PipeDepth      = 3;
  localparam int CycleLimit     = 200_000;
  localparam int NumPhases      = 5;
  localparam int ChunksPerPhase = 110;
  localparam int ExtremePhase   = NumPhases - 1;

  // fixed point corner values of a plane word
  localparam int Unit    = 1024;
  localparam int MaxCoef = 8191;
  localparam int MinCoef = -8192;
  localparam int MaxOff  = 2097151;
  localparam int MinOff  = -2097152;

  // register indexes, the last two are past the plane set
  typedef enum logic [CfgIdxW-1:0] {
    REG_PLANE0, REG_PLANE1, REG_PLANE2, REG_PLANE3, REG_PLANE4, REG_PLANE5,
    REG_SPARE6, REG_SPARE7
  } plane_reg_e;

  typedef enum logic {ROW_WRITE, ROW_CHUNK} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    plane_reg_e               reg_idx;
    logic [CfgDataW-1:0]      word;
    logic signed [ChunkW-1:0] cx;
    logic signed [ChunkW-1:0] cz;
    logic signed [ChunkW-1:0] cy;
    bit                       typed;
    bit                       typed_vis;
  } drill_row_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic signed [ChunkW-1:0]   chunk_x_i;
  logic signed [ChunkW-1:0]   chunk_z_i;
  logic signed [ChunkW-1:0]   chunk_y_i;
  logic                       done_o;
  logic                       visible_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CfgIdxW-1:0]         cfg_index_i;
  logic [CfgDataW-1:0]        cfg_data_i;

  // shadow of the plane registers and visibility still owed by the block
  plane_set_t  plane_shadow;
  bit          pending_visibility [$];
  drill_row_t  drill [$];
  int          idle_pct [NumPhases] = '{0, 79, 17, 79, 0};

  int mismatches;
  int cycles;
  int chunks_sent;
  int results_seen;
  int culled_seen;
  int plane_writes;

  frustum_box_cull dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .chunk_x_i   (chunk_x_i),
    .chunk_z_i   (chunk_z_i),
    .chunk_y_i   (chunk_y_i),
    .done_o      (done_o),
    .visible_o   (visible_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 100 MHz clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // pack one plane into its register layout
  function automatic logic [CfgDataW-1:0] pack_plane(int a, int b, int c, int d);
    plane_t pl;
    pl.a = CoefW'(a);
    pl.b = CoefW'(b);
    pl.c = CoefW'(c);
    pl.d = OffW'(d);
    return pl;
  endfunction

  // visibility of one chunk cube against the shadow planes
  function automatic bit cube_visible(logic signed [ChunkW-1:0] cx,
                                      logic signed [ChunkW-1:0] cz,
                                      logic signed [ChunkW-1:0] cy);
    longint span, base_x, base_y, base_z, px, py, pz, corner_dist;
    bit     vis, any_inside;
    span   = longint'(CubeSide) + 1;
    base_x = longint'(cx) * CubeSide - 1;
    base_z = longint'(cz) * CubeSide - 1;
    base_y = longint'(cy) * CubeSide - 1;
    vis    = 1'b1;
    for (int p = 0; p < NumPlanes; p++) begin
      any_inside = 1'b0;
      for (int k = 0; k < 8; k++) begin
        px   = base_x + (((k & 1) != 0) ? span : 0);
        pz   = base_z + (((k & 2) != 0) ? span : 0);
        py   = base_y + (((k & 4) != 0) ? span : 0);
        corner_dist = longint'($signed(plane_shadow[p].a)) * px
                    + longint'($signed(plane_shadow[p].b)) * py
                    + longint'($signed(plane_shadow[p].c)) * pz
                    + longint'($signed(plane_shadow[p].d));
        if (corner_dist >= 0) any_inside = 1'b1;
      end
      if (!any_inside) vis = 1'b0;
    end
    return vis;
  endfunction

  // mostly near the origin, sometimes anywhere in the field
  function automatic logic signed [ChunkW-1:0] rand_coord();
    if ($urandom_range(9) < 3) return ChunkW'($urandom);
    return ChunkW'(int'($urandom_range(127)) - 64);
  endfunction

  // random plane: raw word, full coefficients near origin, or gentle slopes
  function automatic logic [CfgDataW-1:0] rand_plane();
    logic [CfgDataW-1:0] w;
    case ($urandom_range(2))
      0: w = {$urandom, $urandom};
      1: w = pack_plane(int'($urandom_range(16383)) - 8192, int'($urandom_range(16383)) - 8192,
                        int'($urandom_range(16383)) - 8192, int'($urandom_range(8191)) - 4096);
      default: w = pack_plane(int'($urandom_range(2047)) - 1024,
                              int'($urandom_range(2047)) - 1024,
                              int'($urandom_range(2047)) - 1024, int'($urandom));
    endcase
    return w;
  endfunction

  task automatic add_write(plane_reg_e idx, logic [CfgDataW-1:0] word);
    drill.push_back(drill_row_t'{ROW_WRITE, idx, word, '0, '0, '0, 1'b0, 1'b0});
  endtask

  task automatic add_chunk(int cx, int cz, int cy, bit typed, bit typed_vis);
    drill.push_back(drill_row_t'{ROW_CHUNK, REG_PLANE0, '0, ChunkW'(cx), ChunkW'(cz),
                                 ChunkW'(cy), typed, typed_vis});
  endtask

  // one chunk beat; expectation is the typed value or the predictor's
  task automatic send_chunk(logic signed [ChunkW-1:0] cx, logic signed [ChunkW-1:0] cz,
                            logic signed [ChunkW-1:0] cy, bit typed, bit typed_vis);
    start     <= 1'b1;
    chunk_x_i <= cx;
    chunk_z_i <= cz;
    chunk_y_i <= cy;
    do @(posedge clk_i); while (busy);
    pending_visibility.push_back(typed ? typed_vis : cube_visible(cx, cz, cy));
    chunks_sent++;
  endtask

  // register write once the pipeline has drained
  task automatic write_plane(plane_reg_e idx, logic [CfgDataW-1:0] word);
    start <= 1'b0;
    while (pending_visibility.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 1) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= word;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (int'(idx) < NumPlanes) plane_shadow[int'(idx)] = word;
    plane_writes++;
  endtask

  // result checker, one beat per done strobe
  always @(posedge clk_i) begin : check_results
    bit want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (!visible_o) culled_seen++;
      if (pending_visibility.size() == 0) begin
        $error("visible: no result expected, got %0b", visible_o);
        mismatches++;
      end else begin
        want = pending_visibility.pop_front();
        if (visible_o !== want) begin
          $error("visible: expected %0b, got %0b", want, visible_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int          active;
    logic [CfgDataW-1:0] word;

    rst_ni       = 1'b0;
    start        = 1'b0;
    chunk_x_i    = '0;
    chunk_z_i    = '0;
    chunk_y_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    plane_shadow = '0;
    mismatches   = 0;
    cycles       = 0;
    chunks_sent  = 0;
    results_seen = 0;
    culled_seen  = 0;
    plane_writes = 0;

    // directed rows: reset state, ignored indexes, zero plane, touching corner, extremes
    add_chunk(0, 0, 0, 1'b1, 1'b1);
    add_chunk(-32768, 32767, -32768, 1'b1, 1'b1);
    add_chunk(32767, -32768, 32767, 1'b1, 1'b1);
    add_write(REG_SPARE6, pack_plane(0, 0, 0, -1));
    add_write(REG_SPARE7, pack_plane(0, 0, 0, -1));
    add_chunk(5, -5, 7, 1'b1, 1'b1);
    add_write(REG_PLANE0, pack_plane(0, 0, 0, -1));
    add_chunk(0, 0, 0, 1'b1, 1'b0);
    add_chunk(32767, 32767, 32767, 1'b1, 1'b0);
    add_write(REG_PLANE0, '0);
    add_chunk(0, 0, 0, 1'b1, 1'b1);
    add_write(REG_PLANE0, pack_plane(Unit, 0, 0, 0));
    add_chunk(-1, 0, 0, 1'b0, 1'b0);
    add_chunk(-2, 0, 0, 1'b0, 1'b0);
    add_write(REG_PLANE1, pack_plane(0, -Unit, 0, 0));
    add_chunk(0, 0, 1, 1'b0, 1'b0);
    add_write(REG_PLANE2, pack_plane(0, 0, MaxCoef, MaxOff));
    add_write(REG_PLANE3, pack_plane(MinCoef, MinCoef, MinCoef, MinOff));
    add_write(REG_PLANE4, pack_plane(MaxCoef, MinCoef, MaxCoef, MinOff));
    add_write(REG_PLANE5, pack_plane(MinCoef, MaxCoef, MinCoef, MaxOff));
    add_chunk(32767, 32767, 32767, 1'b0, 1'b0);
    add_chunk(-32768, -32768, -32768, 1'b0, 1'b0);
    add_chunk(0, 0, 0, 1'b0, 1'b0);
    add_chunk(3, -7, -1, 1'b0, 1'b0);
    add_chunk(-32768, 32767, 0, 1'b0, 1'b0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (drill[i]) begin
      if (drill[i].kind == ROW_WRITE) begin
        write_plane(drill[i].reg_idx, drill[i].word);
      end else begin
        send_chunk(drill[i].cx, drill[i].cz, drill[i].cy, drill[i].typed, drill[i].typed_vis);
      end
    end

    // random phases, each with a fresh plane set and its own idle rate
    for (int ph = 0; ph < NumPhases; ph++) begin
      active = $urandom_range(1, NumPlanes);
      for (int r = 0; r < NumPlanes; r++) begin
        if (ph == ExtremePhase) begin
          case (r)
            0: word = pack_plane(MaxCoef, MaxCoef, MaxCoef, MaxOff);
            1: word = pack_plane(MinCoef, MinCoef, MinCoef, MinOff);
            2: word = pack_plane(MaxCoef, MinCoef, 0, 0);
            3: word = pack_plane(0, 0, MinCoef, MaxOff);
            4: word = '1;
            default: word = '0;
          endcase
        end else begin
          word = (r < active) ? rand_plane() : '0;
        end
        write_plane(plane_reg_e'(r), word);
      end
      write_plane($urandom_range(1) ? REG_SPARE7 : REG_SPARE6, {$urandom, $urandom});

      for (int n = 0; n < ChunksPerPhase; n++) begin
        send_chunk(rand_coord(), rand_coord(), rand_coord(), 1'b0, 1'b0);
        if ($urandom_range(99) < idle_pct[ph]) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk_i);
        end
      end
    end

    // drain
    start <= 1'b0;
    while (pending_visibility.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 5) @(posedge clk_i);

    $display("checked %0d chunk results (%0d culled) from %0d chunks sent",
             results_seen, culled_seen, chunks_sent);
    $display("%0d plane register writes over %0d random plane sets plus directed rows",
             plane_writes, NumPhases);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
